[hdl/sfs_pkg.sv]
// Shared types and constants of the sprite frame sequencer.
package sfs_pkg;

    localparam int MAX_FRAMES = 16;
    localparam int IDX_W      = $clog2(MAX_FRAMES);
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
    localparam int INC_W      = 24;
    localparam int PADDR_W    = 3;

    localparam logic REG_LOOP_ENABLE = 1'b0;
    localparam logic REG_SPEED       = 1'b1;

    typedef enum logic [2:0] {
        KIND_TICK    = 3'd0,
        KIND_WRITE   = 3'd1,
        KIND_CLEAR   = 3'd2,
        KIND_SET     = 3'd3,
        KIND_PAUSE   = 3'd4,
        KIND_RESUME  = 3'd5,
        KIND_RESTART = 3'd6,
        KIND_PLAY    = 3'd7
    } kind_t;

    typedef struct packed {
        logic [11:0] left;
        logic [11:0] top;
        logic [11:0] width;
        logic [11:0] height;
    } rect_t;

    typedef struct packed {
        kind_t              kind;
        logic [INC_W-1:0]   inc;
        logic [7:0]         index;
        rect_t              rect;
        logic [23:0]        duration;
    } item_t;

    typedef struct packed {
        logic               loop_enable;
        logic signed [15:0] speed;
    } cfg_t;

    typedef struct packed {
        logic [3:0]       frame_index;
        rect_t            rect;
        logic             paused;
        logic             finished;
        logic [4:0]       frame_total;
    } result_t;

endpackage

[hdl/sfs_if.sv]
// Request and response channel interfaces of the sprite frame sequencer.
interface sfs_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [15:0] delta;
    logic [7:0]  index;
    logic [11:0] rect_left;
    logic [11:0] rect_top;
    logic [11:0] rect_w;
    logic [11:0] rect_h;
    logic [23:0] frame_duration;

    modport source (output valid, kind, delta, index, rect_left, rect_top, rect_w,
                    rect_h, frame_duration, input ready);
    modport sink (input valid, kind, delta, index, rect_left, rect_top, rect_w,
                  rect_h, frame_duration, output ready);
endinterface

interface sfs_rsp_if;
    logic        valid;
    logic        ready;
    logic [3:0]  frame_index;
    logic [11:0] out_left;
    logic [11:0] out_top;
    logic [11:0] out_width;
    logic [11:0] out_height;
    logic        is_paused;
    logic        is_finished;
    logic [4:0]  frame_total;

    modport source (output valid, frame_index, out_left, out_top, out_width, out_height,
                    is_paused, is_finished, frame_total, input ready);
    modport sink (input valid, frame_index, out_left, out_top, out_width, out_height,
                  is_paused, is_finished, frame_total, output ready);
endinterface

[hdl/sfs_core.sv]
// Playback state, frame tables and per-request state update.
module sfs_core
    import sfs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    rect_t             rect_tab_reg [MAX_FRAMES];
    logic [23:0]       dur_tab_reg  [MAX_FRAMES];

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  current_reg, current_next;
    logic [31:0]       elapsed_reg, elapsed_next;
    logic              paused_reg, paused_next;
    logic              finished_reg, finished_next;
    logic [23:0]       cur_dur_reg, cur_dur_next;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_slot;
    logic [32:0]       sum;
    logic [31:0]       el_sat;
    logic [IDX_W-1:0]  last_idx;
    logic [CNT_W-1:0]  cur_plus;
    logic              neg;
    logic              have_frames;
    rect_t             rect_sel;

    assign neg         = cfg.speed[15];
    assign have_frames = (count_reg != '0);
    assign last_idx    = IDX_W'(count_reg - CNT_W'(1));
    assign cur_plus    = CNT_W'(current_reg) + CNT_W'(1);
    assign sum         = {1'b0, elapsed_reg} + 33'(item.inc);
    assign el_sat      = sum[32] ? '1 : sum[31:0];

    always_comb
    begin
        count_next    = count_reg;
        current_next  = current_reg;
        elapsed_next  = elapsed_reg;
        paused_next   = paused_reg;
        finished_next = finished_reg;
        wr_en         = 1'b0;
        wr_slot       = IDX_W'(item.index);
        case (item.kind)
            KIND_TICK:
            begin
                if (have_frames && !paused_reg && !finished_reg)
                begin
                    elapsed_next = el_sat;
                    if (el_sat >= 32'(cur_dur_reg))
                    begin
                        elapsed_next = '0;
                        if (!neg)
                        begin
                            if (cur_plus < count_reg)
                                current_next = current_reg + IDX_W'(1);
                            else if (cfg.loop_enable)
                                current_next = '0;
                            else
                            begin
                                current_next  = last_idx;
                                paused_next   = 1'b1;
                                finished_next = 1'b1;
                            end
                        end
                        else
                        begin
                            if (current_reg != '0)
                                current_next = current_reg - IDX_W'(1);
                            else if (cfg.loop_enable)
                                current_next = last_idx;
                            else
                            begin
                                current_next  = '0;
                                paused_next   = 1'b1;
                                finished_next = 1'b1;
                            end
                        end
                    end
                end
            end
            KIND_WRITE:
            begin
                if (item.index >= 8'(count_reg))
                begin
                    if (count_reg < CNT_W'(MAX_FRAMES))
                    begin
                        wr_en      = 1'b1;
                        wr_slot    = IDX_W'(count_reg);
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                else
                    wr_en = 1'b1;
            end
            KIND_CLEAR:
            begin
                count_next   = '0;
                current_next = '0;
            end
            KIND_SET:
            begin
                if (have_frames)
                begin
                    current_next = (item.index >= 8'(count_reg)) ? last_idx
                                                                 : IDX_W'(item.index);
                    elapsed_next = '0;
                end
            end
            KIND_PAUSE:
                paused_next = 1'b1;
            KIND_RESUME:
                paused_next = 1'b0;
            KIND_RESTART, KIND_PLAY:
            begin
                if (have_frames)
                    current_next = neg ? last_idx : '0;
                elapsed_next  = '0;
                finished_next = 1'b0;
                if (item.kind == KIND_PLAY)
                    paused_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // current frame after this request, with the same-request write bypassed
    always_comb
    begin
        if (wr_en && (wr_slot == current_next))
        begin
            rect_sel     = item.rect;
            cur_dur_next = item.duration;
        end
        else
        begin
            rect_sel     = rect_tab_reg[current_next];
            cur_dur_next = dur_tab_reg[current_next];
        end
    end

    always_comb
    begin
        result.frame_index = 4'(current_next);
        result.rect        = (count_next != '0) ? rect_sel : '0;
        result.paused      = paused_next;
        result.finished    = finished_next;
        result.frame_total = 5'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            current_reg  <= '0;
            elapsed_reg  <= '0;
            paused_reg   <= 1'b1;
            finished_reg <= 1'b0;
        end
        else if (advance)
        begin
            count_reg    <= count_next;
            current_reg  <= current_next;
            elapsed_reg  <= elapsed_next;
            paused_reg   <= paused_next;
            finished_reg <= finished_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cur_dur_reg <= cur_dur_next;
            if (wr_en)
            begin
                rect_tab_reg[wr_slot] <= item.rect;
                dur_tab_reg[wr_slot]  <= item.duration;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_FRAMES))
        else $error("frame count above table size");

    a_current_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (CNT_W'(current_reg) < count_reg))
        else $error("current frame outside table");

    a_finish_pauses: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(finished_reg) |-> paused_reg)
        else $error("finished set without pause");

endmodule

[hdl/sprite_frame_sequencer_top.sv]
// Top level of the sprite frame sequencer: channels, config port, pipeline registers.
//
// Usage:
//   req carries one request per valid/ready handshake: tick, write frame, clear,
//   set frame, pause, resume, restart or play. rsp returns exactly one response
//   per request with the current frame index, its rectangle, the paused and
//   finished flags and the frame count, in request order.
//   The APB port holds loop_enable (0x0) and speed (0x4, signed Q8.8); write
//   them only while no request is in flight.
//   Pipeline: an accepted request is held in the request register, and its
//   result then in the response register, which drives rsp.valid. The tick
//   scaling multiply sits ahead of the request register; timer add, frame
//   step and table read sit between request register and response register.
//   Throughput: one request per cycle while rsp.ready stays high.
//   Reset: table empty, frame 0, timer 0, paused, not finished, loop on,
//   speed 1.0. Frame table contents are undefined until written.
//   Stall: when rsp.ready is low the response is held, one more request may
//   sit in the request register, and then req.ready drops.
module sprite_frame_sequencer_top
    import sfs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    sfs_req_if.sink            req,
    sfs_rsp_if.source          rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    cfg_t        cfg_reg;
    item_t       item_reg;
    logic        item_valid_reg;
    result_t     res_reg;
    logic        res_valid_reg;
    result_t     res_next;
    logic        advance;
    logic [15:0] speed_mag;
    logic [31:0] product;
    logic        cfg_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign prdata  = (paddr[2] == REG_SPEED) ? {16'b0, cfg_reg.speed}
                                             : {31'b0, cfg_reg.loop_enable};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.loop_enable <= 1'b1;
            cfg_reg.speed       <= 16'sd256;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_SPEED)
                cfg_reg.speed <= pwdata[15:0];
            else
                cfg_reg.loop_enable <= pwdata[0];
        end
    end

    // |speed| * delta; the Q8.8 scale is removed by taking product[31:8]
    assign speed_mag = cfg_reg.speed[15] ? (~cfg_reg.speed + 16'd1) : cfg_reg.speed;
    assign product   = 32'(req.delta) * 32'(speed_mag);

    assign advance   = item_valid_reg && (!res_valid_reg || rsp.ready);
    assign req.ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (req.ready)
                item_valid_reg <= req.valid;
            if (advance)
                res_valid_reg <= 1'b1;
            else if (rsp.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            item_reg.kind        <= kind_t'(req.kind);
            item_reg.inc         <= product[31:8];
            item_reg.index       <= req.index;
            item_reg.rect.left   <= req.rect_left;
            item_reg.rect.top    <= req.rect_top;
            item_reg.rect.width  <= req.rect_w;
            item_reg.rect.height <= req.rect_h;
            item_reg.duration    <= req.frame_duration;
        end
        if (advance)
            res_reg <= res_next;
    end

    sfs_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .result  (res_next)
    );

    assign rsp.valid       = res_valid_reg;
    assign rsp.frame_index = res_reg.frame_index;
    assign rsp.out_left    = res_reg.rect.left;
    assign rsp.out_top     = res_reg.rect.top;
    assign rsp.out_width   = res_reg.rect.width;
    assign rsp.out_height  = res_reg.rect.height;
    assign rsp.is_paused   = res_reg.paused;
    assign rsp.is_finished = res_reg.finished;
    assign rsp.frame_total = res_reg.frame_total;

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg)
        else $error("response register not loaded");

    a_no_advance_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !rsp.ready && item_valid_reg) |-> !req.ready)
        else $error("request taken with both stages full");

    a_rsp_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !rsp.ready) |=> (res_valid_reg && $stable(res_reg)))
        else $error("stalled response changed");

endmodule
